### rtl/tone_curve_saturation_pixel_assert.svh
// Assertion macros shared by the RTL of the tone curve block.
`ifndef TONE_CURVE_SATURATION_PIXEL_ASSERT_SVH
`define TONE_CURVE_SATURATION_PIXEL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tone curve block: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tone curve block: next-cycle check failed");

`endif

### rtl/tcs_pkg.sv
package tcs_pkg;

	localparam int CURVE_ENTRIES = 256;
	localparam int CURVE_AW      = $clog2(CURVE_ENTRIES);
	localparam int PIX_W         = 8;
	localparam int GAIN_W        = 10;
	localparam int LUMA_W        = 24;
	localparam int LANES         = 3;

	// Rec.709 luma weights in Q16; they sum to exactly 65536.
	localparam logic [15:0] LUMA_R = 16'd13933;
	localparam logic [15:0] LUMA_G = 16'd46871;
	localparam logic [15:0] LUMA_B = 16'd4732;

	// Input kinds carried on tuser.
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	// Curve select codes; lane i holds the curve with code i.
	localparam logic [1:0] SEL_BLUE  = 2'd0;
	localparam logic [1:0] SEL_GREEN = 2'd1;
	localparam logic [1:0] SEL_RED   = 2'd2;

	// Register indexes (byte address bit 2).
	localparam logic REG_GAIN   = 1'b0;
	localparam logic REG_BYPASS = 1'b1;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd256;

	// Input tdata layout.
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 32;
	localparam int ALPHA_LSB = 24;
	localparam int SEL_LSB   = 32;
	localparam int IDX_LSB   = 34;
	localparam int VAL_LSB   = 42;

	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
		logic en4;
	} pipe_en_t;

endpackage

### rtl/tcs_curve.sv
module tcs_curve
	import tcs_pkg::*;
(
	input  logic                clk,
	input  logic                we,
	input  logic [CURVE_AW-1:0] waddr,
	input  logic [PIX_W-1:0]    wdata,
	input  logic                re,
	input  logic [CURVE_AW-1:0] raddr,
	output logic [PIX_W-1:0]    rdata_s1
);

	logic [PIX_W-1:0] mem [CURVE_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

endmodule

### rtl/tcs_luma.sv
module tcs_luma
	import tcs_pkg::*;
(
	input  logic              clk,
	input  pipe_en_t          en,
	input  logic [PIX_W-1:0]  cb_s1,
	input  logic [PIX_W-1:0]  cg_s1,
	input  logic [PIX_W-1:0]  cr_s1,
	output logic [LUMA_W-1:0] y16_s2
);

	logic [LUMA_W-1:0] pr, pg, pb;

	assign pr = {8'd0, LUMA_R} * {16'd0, cr_s1};
	assign pg = {8'd0, LUMA_G} * {16'd0, cg_s1};
	assign pb = {8'd0, LUMA_B} * {16'd0, cb_s1};

	// The weights sum to 65536, so the total never exceeds 24 bits.
	always_ff @(posedge clk) begin
		if (en.en2) begin
			y16_s2 <= pr + pg + pb;
		end
	end

endmodule

### rtl/tcs_blend.sv
module tcs_blend
	import tcs_pkg::*;
(
	input  logic              clk,
	input  pipe_en_t          en,
	input  logic [PIX_W-1:0]  c_s1,
	input  logic [LUMA_W-1:0] y16_s2,
	input  logic [GAIN_W-1:0] gain,
	output logic [PIX_W-1:0]  res_s4
);

	logic        [PIX_W-1:0]  c_s2;
	logic signed [25:0]       diff;
	logic signed [36:0]       prod;
	logic signed [36:0]       prod_s3;
	logic        [LUMA_W-1:0] y16_s3;
	logic signed [37:0]       v;
	logic        [37:0]       rnd;

	always_ff @(posedge clk) begin
		if (en.en2) begin
			c_s2 <= c_s1;
		end
	end

	assign diff = $signed({2'b00, c_s2, 16'd0}) - $signed({2'b00, y16_s2});
	assign prod = diff * $signed({1'b0, gain});

	always_ff @(posedge clk) begin
		if (en.en3) begin
			prod_s3 <= prod;
			y16_s3  <= y16_s2;
		end
	end

	assign v   = $signed({6'd0, y16_s3, 8'd0}) + $signed({prod_s3[36], prod_s3});
	assign rnd = unsigned'(v) + 38'd8388608;

	always_ff @(posedge clk) begin
		if (en.en4) begin
			if (v <= 38'sd0) begin
				res_s4 <= '0;
			end else if (|rnd[37:32]) begin
				res_s4 <= '1;
			end else begin
				res_s4 <= rnd[31:24];
			end
		end
	end

endmodule

### rtl/tone_curve_saturation_pixel.sv
// Tone curve and saturation stage for a BGRA pixel stream.
// Items arrive on the s_axis channel. tuser says whether the transaction is a
// pixel or a curve entry write; a write updates one byte of the blue, green or
// red curve and gives no output. A pixel is looked up in the three curves in
// parallel, blended around its luma by the saturation gain and leaves on the
// m_axis channel with alpha and tlast copied. In bypass mode the colour bytes
// are copied unchanged.
// The stages are curve read, luma sum, gain multiply, round and clamp. One item
// is taken every cycle while the receiver does not stall the pipeline.
// A curve entry must be written before a pixel reads it; writes take effect for
// the very next transaction.
// Reset clears the pipeline valid flags and sets the gain to 256 and bypass on;
// the curve contents are not cleared. When the receiver stalls, the result
// holds on m_axis and earlier stages keep filling, so up to four pixels are
// taken before s_axis_tready falls.
// Registers on the APB port: gain at address 0, bypass at address 4.
module tone_curve_saturation_pixel
	import tcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// APB configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// input stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// in_blue, in_green, in_red, in_alpha, curve_select, curve_index, curve_value, 6'b0
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	input  logic                 s_axis_tuser,   // kind
	input  logic                 s_axis_tlast,   // last_in_frame
	// output stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// out_blue, out_green, out_red, out_alpha
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	output logic                 m_axis_tlast    // frame_end
);

	logic [GAIN_W-1:0] gain_q;
	logic              bypass_q;

	logic v1_s1, v2_s2, v3_s3, v4_s4;
	pipe_en_t en;
	logic acc, acc_pix, acc_wr;

	logic [1:0]          wsel;
	logic [CURVE_AW-1:0] widx;
	logic [PIX_W-1:0]    wval;

	logic [PIX_W-1:0]  c_s1   [LANES];
	logic [PIX_W-1:0]  res_s4 [LANES];
	logic [LUMA_W-1:0] y16_s2;

	logic [3*PIX_W-1:0] raw_s1, raw_s2, raw_s3, raw_s4;
	logic [PIX_W-1:0]   alpha_s1, alpha_s2, alpha_s3, alpha_s4;
	logic               last_s1, last_s2, last_s3, last_s4;
	logic               byp_s1, byp_s2, byp_s3, byp_s4;

	// Configuration port.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			bypass_q <= 1'b1;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_GAIN:   gain_q   <= pwdata[GAIN_W-1:0];
				REG_BYPASS: bypass_q <= pwdata[0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_GAIN:   prdata = {{(32-GAIN_W){1'b0}}, gain_q};
			REG_BYPASS: prdata = {31'd0, bypass_q};
			default:    prdata = '0;
		endcase
	end

	// Each stage moves on when the stage after it is empty or moving.
	assign en.en4 = !v4_s4 || m_axis_tready;
	assign en.en3 = !v3_s3 || en.en4;
	assign en.en2 = !v2_s2 || en.en3;
	assign en.en1 = !v1_s1 || en.en2;

	assign s_axis_tready = en.en1;
	assign acc     = s_axis_tvalid && s_axis_tready;
	assign acc_pix = acc && (s_axis_tuser == KIND_PIXEL);
	assign acc_wr  = acc && (s_axis_tuser == KIND_WRITE);

	assign wsel = s_axis_tdata[SEL_LSB +: 2];
	assign widx = s_axis_tdata[IDX_LSB +: CURVE_AW];
	assign wval = s_axis_tdata[VAL_LSB +: PIX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (en.en1) v1_s1 <= acc_pix;
			if (en.en2) v2_s2 <= v1_s1;
			if (en.en3) v3_s3 <= v2_s2;
			if (en.en4) v4_s4 <= v3_s3;
		end
	end

	// Pass-through fields travel beside the colour lanes.
	always_ff @(posedge clk) begin
		if (en.en1) begin
			raw_s1   <= s_axis_tdata[3*PIX_W-1:0];
			alpha_s1 <= s_axis_tdata[ALPHA_LSB +: PIX_W];
			last_s1  <= s_axis_tlast;
			byp_s1   <= bypass_q;
		end
		if (en.en2) begin
			raw_s2   <= raw_s1;
			alpha_s2 <= alpha_s1;
			last_s2  <= last_s1;
			byp_s2   <= byp_s1;
		end
		if (en.en3) begin
			raw_s3   <= raw_s2;
			alpha_s3 <= alpha_s2;
			last_s3  <= last_s2;
			byp_s3   <= byp_s2;
		end
		if (en.en4) begin
			raw_s4   <= raw_s3;
			alpha_s4 <= alpha_s3;
			last_s4  <= last_s3;
			byp_s4   <= byp_s3;
		end
	end

	// One lane per colour: blue, green, red, matching the curve select codes.
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		tcs_curve u_curve (
			.clk      (clk),
			.we       (acc_wr && (wsel == 2'(i))),
			.waddr    (widx),
			.wdata    (wval),
			.re       (en.en1),
			.raddr    (s_axis_tdata[i*PIX_W +: CURVE_AW]),
			.rdata_s1 (c_s1[i])
		);

		tcs_blend u_blend (
			.clk    (clk),
			.en     (en),
			.c_s1   (c_s1[i]),
			.y16_s2 (y16_s2),
			.gain   (gain_q),
			.res_s4 (res_s4[i])
		);
	end

	tcs_luma u_luma (
		.clk    (clk),
		.en     (en),
		.cb_s1  (c_s1[SEL_BLUE]),
		.cg_s1  (c_s1[SEL_GREEN]),
		.cr_s1  (c_s1[SEL_RED]),
		.y16_s2 (y16_s2)
	);

	assign m_axis_tvalid = v4_s4;
	assign m_axis_tlast  = last_s4;
	assign m_axis_tdata  = byp_s4 ? {alpha_s4, raw_s4}
	                              : {alpha_s4, res_s4[SEL_RED], res_s4[SEL_GREEN],
	                                 res_s4[SEL_BLUE]};

`include "tone_curve_saturation_pixel_assert.svh"

	`TCS_ASSERT_NEXT(a_write_no_result, clk, arst_n, acc_wr, !v1_s1)
	`TCS_ASSERT_NEXT(a_pixel_enters, clk, arst_n, acc_pix, v1_s1)
	`TCS_ASSERT_NOW(a_full_stall, clk, arst_n,
		v1_s1 && v2_s2 && v3_s3 && v4_s4 && !m_axis_tready, !s_axis_tready)

endmodule
